>>> rtl/core/oic_pkg.sv
// Shared types and constants for the online inversion counter.
`default_nettype none

package oic_pkg;

  localparam int DEPTH  = 1024;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int POS_W  = 10;
  localparam int VAL_W  = 10;
  localparam int NEW_W  = 10;
  localparam int TOT_W  = 19;
  localparam int CNT_W  = ADDR_W + 1;
  localparam int SUM_W  = ((CNT_W > TOT_W) ? CNT_W : TOT_W) + 1;

  localparam logic [NEW_W-1:0] NEW_MAX   = '1;
  localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

  localparam logic CMD_CLEAR  = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_REJECTED = 1'b1;

  // One stored slot: occupied flag plus the value held there.
  typedef struct packed {
    logic             occupied;
    logic [VAL_W-1:0] value;
  } slot_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

>>> rtl/core/oic_in_if.sv
// Input channel: insert or clear commands.
`default_nettype none

interface oic_in_if
  import oic_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             command;
  logic [POS_W-1:0] position;
  logic [VAL_W-1:0] value;

  modport source (output valid, output command, output position, output value, input ready);
  modport sink   (input valid, input command, input position, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/oic_out_if.sv
// Result channel: per-item inversion counts and status.
`default_nettype none

interface oic_out_if
  import oic_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [NEW_W-1:0] new_inversions;
  logic [TOT_W-1:0] total_inversions;
  logic             status;

  modport source (output valid, output new_inversions, output total_inversions,
                  output status, input ready);
  modport sink   (input valid, input new_inversions, input total_inversions,
                  input status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/online_inversion_counter.sv
// Online inversion counter: slot memory scan, one slot read per cycle.
// Flow: an insert goes through ST_SCAN and ST_DRAIN to ST_FINISH, a clear through
//   ST_CLEAR; an insert at or beyond DEPTH goes straight to ST_FINISH, rejected.
// Throughput: a new item is taken only once the last result is loaded; scan speed is
//   set by the single read port of the slot RAM, which the count walks one entry per cycle.
// Reset: synchronous, active low; afterwards a clearing pass over the
//   slot RAM runs with in_ch.ready low. Total resets to zero.
`default_nettype none

module online_inversion_counter
  import oic_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  oic_in_if.sink    in_ch,
  oic_out_if.source out_ch
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

  state_t state_r, state_nxt;

  // scan / sweep address and read pipeline tracking
  logic [ADDR_W-1:0] scan_addr_r, scan_addr_nxt;
  logic [ADDR_W-1:0] rd_addr_r,   rd_addr_nxt;
  logic              pend_r,      pend_nxt;

  // latched item
  logic              cmd_r,      cmd_nxt;
  logic [ADDR_W-1:0] pos_addr_r, pos_addr_nxt;
  logic [VAL_W-1:0]  val_r,      val_nxt;
  logic              hit_r,      hit_nxt;   // occupied slot or out of range
  logic [CNT_W-1:0]  cnt_r,      cnt_nxt;

  logic [TOT_W-1:0]  total_r,    total_nxt;

  // result register
  logic              out_valid_r,  out_valid_nxt;
  logic [NEW_W-1:0]  out_new_r,    out_new_nxt;
  logic [TOT_W-1:0]  out_total_r,  out_total_nxt;
  logic              out_status_r, out_status_nxt;

  // FSM outputs
  logic              in_ready;
  logic              out_load;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  slot_t             ram_wdata;
  logic              ram_re;
  slot_t             ram_rdata;

  logic              in_fire;
  logic              in_oob;
  logic              last_addr;
  logic [SUM_W-1:0]  sum;
  logic [TOT_W-1:0]  total_sat;
  logic [NEW_W-1:0]  new_sat;

  assign in_fire   = in_ch.valid && in_ready;
  assign in_oob    = 32'(in_ch.position) >= 32'(DEPTH);
  assign last_addr = (scan_addr_r == LAST_ADDR);

  oic_ram #(
    .WIDTH ($bits(slot_t)),
    .DEPTH (DEPTH)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (scan_addr_r),
    .rdata (ram_rdata)
  );

  // ---------------- next state ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT: begin
        if (last_addr) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_fire) begin
          priority if (in_ch.command == CMD_CLEAR) state_nxt = ST_CLEAR;
          else if (in_oob)                         state_nxt = ST_FINISH;
          else                                     state_nxt = ST_SCAN;
        end
      end
      ST_CLEAR: begin
        if (last_addr) state_nxt = ST_FINISH;
      end
      ST_SCAN: begin
        if (last_addr) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  // ---------------- FSM outputs ----------------
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = scan_addr_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    unique case (state_r)
      ST_INIT, ST_CLEAR: begin
        ram_we = 1'b1;                       // sweep: mark slot empty
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_SCAN: begin
        ram_re = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        out_load           = !out_valid_r || out_ch.ready;
        ram_waddr          = pos_addr_r;
        ram_wdata.occupied = 1'b1;
        ram_wdata.value    = val_r;
        ram_we             = out_load && (cmd_r == CMD_INSERT) && !hit_r;
      end
      default: begin
      end
    endcase
  end

  // ---------------- saturating sums ----------------
  always_comb begin
    sum       = SUM_W'(total_r) + SUM_W'(cnt_r);
    total_sat = (sum >= SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : TOT_W'(sum);
    new_sat   = (32'(cnt_r) > 32'(NEW_MAX)) ? NEW_MAX : NEW_W'(cnt_r);
  end

  // ---------------- datapath next values ----------------
  always_comb begin
    scan_addr_nxt  = scan_addr_r;
    rd_addr_nxt    = scan_addr_r;
    pend_nxt       = (state_r == ST_SCAN);
    cmd_nxt        = cmd_r;
    pos_addr_nxt   = pos_addr_r;
    val_nxt        = val_r;
    hit_nxt        = hit_r;
    cnt_nxt        = cnt_r;
    total_nxt      = total_r;
    out_new_nxt    = out_new_r;
    out_total_nxt  = out_total_r;
    out_status_nxt = out_status_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;

    if (state_r == ST_INIT || state_r == ST_CLEAR || state_r == ST_SCAN) begin
      scan_addr_nxt = last_addr ? '0 : ADDR_W'(scan_addr_r + 1'b1);
    end

    if (in_fire) begin
      cmd_nxt       = in_ch.command;
      pos_addr_nxt  = ADDR_W'(in_ch.position);
      val_nxt       = in_ch.value;
      hit_nxt       = in_oob;
      cnt_nxt       = '0;
      scan_addr_nxt = '0;
    end

    // slot data returns in the cycle after its read
    if (pend_r && ram_rdata.occupied) begin
      if (rd_addr_r == pos_addr_r) begin
        hit_nxt = 1'b1;
      end else if ((rd_addr_r < pos_addr_r && ram_rdata.value > val_r) ||
                   (rd_addr_r > pos_addr_r && ram_rdata.value < val_r)) begin
        cnt_nxt = CNT_W'(cnt_r + 1'b1);
      end
    end

    if (out_load) begin
      out_valid_nxt = 1'b1;
      priority if (cmd_r == CMD_CLEAR) begin
        total_nxt      = '0;
        out_new_nxt    = '0;
        out_total_nxt  = '0;
        out_status_nxt = STATUS_OK;
      end else if (hit_r) begin
        out_new_nxt    = '0;
        out_total_nxt  = total_r;
        out_status_nxt = STATUS_REJECTED;
      end else begin
        total_nxt      = total_sat;
        out_new_nxt    = new_sat;
        out_total_nxt  = total_sat;
        out_status_nxt = STATUS_OK;
      end
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      scan_addr_r <= '0;
      pend_r      <= 1'b0;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      scan_addr_r <= scan_addr_nxt;
      pend_r      <= pend_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r    <= rd_addr_nxt;
    cmd_r        <= cmd_nxt;
    pos_addr_r   <= pos_addr_nxt;
    val_r        <= val_nxt;
    hit_r        <= hit_nxt;
    cnt_r        <= cnt_nxt;
    out_new_r    <= out_new_nxt;
    out_total_r  <= out_total_nxt;
    out_status_r <= out_status_nxt;
  end

  assign in_ch.ready             = in_ready;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.new_inversions   = out_new_r;
  assign out_ch.total_inversions = out_total_r;
  assign out_ch.status           = out_status_r;

`ifndef SYNTH
  // slot RAM is written only by a sweep or at the end of an insert
  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_INIT || state_r == ST_CLEAR || state_r == ST_FINISH))
    else $error("slot RAM written outside sweep or finish");

  // an in-range insert starts its scan from slot zero
  a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.command == CMD_INSERT && !in_oob)
      |=> (state_r == ST_SCAN && scan_addr_r == '0 && cnt_r == '0))
    else $error("scan did not start at slot zero");

  // a loaded result shows up on the output next cycle
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_ch.valid)
    else $error("loaded result not presented");

  // a rejected insert never touches the running total
  a_reject_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && cmd_r == CMD_INSERT && hit_r) |=> total_r == $past(total_r))
    else $error("total changed on rejected insert");
`endif

endmodule

`default_nettype wire

>>> rtl/core/oic_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module oic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> tb/oic_checker.sv
// Scoreboard for the online inversion counter: mirrors the slot store and checks each result.
`timescale 1ns / 100ps

module oic_checker
  import oic_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  oic_in_if    in_mon,
  oic_out_if   out_mon,
  output int   fail_count,
  output int   awaited,
  output int   n_inserted,
  output int   n_rejected,
  output int   n_cleared,
  output int   peak_total
);

  typedef struct packed {
    logic [NEW_W-1:0] new_inv;
    logic [TOT_W-1:0] total;
    logic             status;
  } tally_t;

  logic [VAL_W-1:0] slot_val  [DEPTH];
  bit               slot_used [DEPTH];
  logic [TOT_W:0]   run_total;    // one bit of headroom, held at TOTAL_MAX
  tally_t           tally_q [$];  // expected results, oldest first

  function automatic void wipe_slots();
    foreach (slot_used[j]) slot_used[j] = 1'b0;
    run_total = '0;
  endfunction

  // Applies one item to the mirrored store and returns the result it must produce.
  function automatic tally_t count_and_insert(logic cmd, logic [POS_W-1:0] pos,
                                              logic [VAL_W-1:0] val);
    tally_t      t;
    int unsigned cnt;
    t   = '0;
    cnt = 0;
    if (cmd == CMD_CLEAR) begin
      wipe_slots();
      n_cleared++;
      return t;
    end
    if (int'(pos) >= DEPTH || slot_used[pos]) begin
      t.total  = run_total[TOT_W-1:0];
      t.status = STATUS_REJECTED;
      n_rejected++;
      return t;
    end
    for (int j = 0; j < DEPTH; j++) begin
      if (slot_used[j] && ((j < pos && slot_val[j] > val) || (j > pos && slot_val[j] < val)))
        cnt++;
    end
    slot_used[pos] = 1'b1;
    slot_val[pos]  = val;
    if (cnt >= TOTAL_MAX - run_total) run_total = (TOT_W+1)'(TOTAL_MAX);
    else run_total = run_total + (TOT_W+1)'(cnt);
    t.new_inv = (cnt > NEW_MAX) ? NEW_MAX : cnt[NEW_W-1:0];
    t.total   = run_total[TOT_W-1:0];
    t.status  = STATUS_OK;
    n_inserted++;
    return t;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    tally_t want;
    if (!rst_n) begin
      wipe_slots();
      tally_q.delete();
    end else begin
      // Result side first: a result in the same cycle belongs to an older item.
      if (out_mon.valid && out_mon.ready) begin
        if (tally_q.size() == 0) begin
          fail_count++;
          $display("%0t ns: result with none pending, new %0d total %0d status %0d", $time,
                   out_mon.new_inversions, out_mon.total_inversions, out_mon.status);
        end else begin
          want = tally_q.pop_front();
          check_field("new_inversions", 32'(want.new_inv), 32'(out_mon.new_inversions));
          check_field("total_inversions", 32'(want.total), 32'(out_mon.total_inversions));
          check_field("status", 32'(want.status), 32'(out_mon.status));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        want = count_and_insert(in_mon.command, in_mon.position, in_mon.value);
        tally_q.push_back(want);
        if (int'(want.total) > peak_total) peak_total = int'(want.total);
      end
    end
    awaited = tally_q.size();
  end

endmodule

>>> tb/tb.sv
// Testbench top for the online inversion counter: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;
  import oic_pkg::*;

  // Watchdog limit for ~600 items plus stalls; it leaves several times the slowest good run.
  localparam int CYCLE_LIMIT     = 3_000_000;
  localparam int ITEM_TARGET     = 580;
  localparam int HOLD_OFF_CYCLES = 4000;       // longer than one item, so input backs up
  localparam int SETTLE_CYCLES   = DEPTH + 16; // one full slot scan plus margin

  // How values are chosen inside one insert phase.
  typedef enum int {
    STYLE_RANDOM,    // distinct random values
    STYLE_REVERSED,  // value falls as position rises: every such pair inverts
    STYLE_SORTED     // value equals position: no inversions among these
  } fill_style_t;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned cycle_count = 0;

  oic_in_if  in_ch ();
  oic_out_if out_ch ();

  int fail_count, awaited, n_inserted, n_rejected, n_cleared, peak_total;

  int items_sent   = 0;
  int hold_off_len = 0;   // one-shot request to the receiver process
  bit steady       = 1'b0; // no random idling on either side while set

  // Stimulus-side view of what is stored, only to shape well-formed inserts.
  bit pos_taken [DEPTH];
  bit val_taken [DEPTH];
  int taken_pos_q [$];
  int taken_val_q [$];

  online_inversion_counter dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  oic_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .fail_count (fail_count),
    .awaited    (awaited),
    .n_inserted (n_inserted),
    .n_rejected (n_rejected),
    .n_cleared  (n_cleared),
    .peak_total (peak_total)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still pending", cycle_count, awaited);
    $display("Simulation FAILED");
    $finish;
  end

  // Result receiver: random stall before each transfer (none while steady), or one long hold-off
  // when the stimulus asks for it. Ready changes only on falling edges.
  initial begin : receiver
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n);
    forever begin
      if (hold_off_len > 0) begin
        stall        = hold_off_len;
        hold_off_len = 0;
      end else if (steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, 16);
      end
      repeat (stall) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  function automatic void forget_set();
    foreach (pos_taken[j]) pos_taken[j] = 1'b0;
    foreach (val_taken[j]) val_taken[j] = 1'b0;
    taken_pos_q.delete();
    taken_val_q.delete();
  endfunction

  // Drives one item after a random gap (none while steady) and returns once it has transferred.
  // Valid stays high across back-to-back items; here it only drops during a gap.
  task automatic send_item(logic cmd, int pos, int val);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid    = 1'b1;
    in_ch.command  = cmd;
    in_ch.position = POS_W'(pos);
    in_ch.value    = VAL_W'(val);
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (cmd == CMD_CLEAR) begin
      forget_set();
    end else if (!pos_taken[pos]) begin
      pos_taken[pos] = 1'b1;
      taken_pos_q.push_back(pos);
      if (!val_taken[val]) begin
        val_taken[val] = 1'b1;
        taken_val_q.push_back(val);
      end
    end
  endtask

  // Drops valid so the last item is not offered again, then waits for every result.
  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (awaited == 0);
  endtask

  // Fewer than DEPTH items are sent in all, so a free slot always exists.
  function automatic int fresh_pos();
    int p;
    do p = $urandom_range(0, DEPTH-1); while (pos_taken[p]);
    return p;
  endfunction

  function automatic int fresh_val();
    int v;
    do v = $urandom_range(0, DEPTH-1); while (val_taken[v]);
    return v;
  endfunction

  // Mostly well-formed inserts; some hit an occupied slot, some repeat a
  // stored value, some are pure noise.
  task automatic insert_next(fill_style_t style);
    int pos, val, roll;
    roll = $urandom_range(0, 99);
    if (roll < 8 && taken_pos_q.size() > 0) begin
      pos = taken_pos_q[$urandom_range(0, taken_pos_q.size()-1)];
      val = $urandom_range(0, DEPTH-1);
    end else if (roll < 12) begin
      pos = $urandom_range(0, DEPTH-1);
      val = $urandom_range(0, DEPTH-1);
    end else begin
      pos = fresh_pos();
      if (roll < 17 && taken_val_q.size() > 0) begin
        val = taken_val_q[$urandom_range(0, taken_val_q.size()-1)];
      end else begin
        case (style)
          STYLE_REVERSED: val = DEPTH - 1 - pos;
          STYLE_SORTED:   val = pos;
          default:        val = fresh_val();
        endcase
      end
    end
    send_item(CMD_INSERT, pos, val);
  endtask

  initial begin : stimulus
    int          phase_len;
    bit          first_phase;
    fill_style_t style;

    in_ch.valid    = 1'b0;
    in_ch.command  = CMD_CLEAR;
    in_ch.position = '0;
    in_ch.value    = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // --- Directed part ---
    // Clear with all-ones operands: they must be ignored.
    send_item(CMD_CLEAR, DEPTH-1, DEPTH-1);
    // Extreme corners of the field ranges.
    send_item(CMD_INSERT, 0, DEPTH-1);
    send_item(CMD_INSERT, DEPTH-1, 0);        // inverts with the first
    send_item(CMD_INSERT, 512, 512);          // inverts with both ends
    send_item(CMD_INSERT, 511, 512);          // equal value next door: no inversion there
    // Occupied slots at both ends: rejected, total unchanged.
    send_item(CMD_INSERT, 0, 5);
    send_item(CMD_INSERT, DEPTH-1, DEPTH-1);
    send_item(CMD_INSERT, 1, 0);              // repeats the value held at the top slot
    send_item(CMD_INSERT, DEPTH-2, DEPTH-1);
    // Alternating bit patterns on position and value.
    send_item(CMD_INSERT, 'h155, 'h2AA);
    send_item(CMD_INSERT, 'h2AA, 'h155);
    // Two clears back to back, then reuse a slot freed by the clear.
    send_item(CMD_CLEAR, 0, 0);
    send_item(CMD_CLEAR, 'h2AA, 'h155);
    send_item(CMD_INSERT, 0, 0);
    // Falling run: each new element inverts with all earlier ones of the run.
    for (int i = 0; i < 5; i++) send_item(CMD_INSERT, 100 + i, 900 - i);
    send_item(CMD_INSERT, DEPTH-1, DEPTH-1);

    // Sender pauses until every result is back.
    drain_results();

    // Receiver holds off for a long stretch while the sender keeps offering
    // items, so the result slot fills and the block stalls its input.
    hold_off_len = HOLD_OFF_CYCLES;
    steady       = 1'b1;
    repeat (6) insert_next(STYLE_RANDOM);
    steady = 1'b0;
    drain_results();

    // --- Random part ---
    // First phase is long and fully reversed to build up a large total; the
    // rest are short phases of mixed styles, mostly starting from a clear.
    first_phase = 1'b1;
    style       = STYLE_REVERSED;
    phase_len   = 256;
    while (items_sent < ITEM_TARGET) begin
      if (first_phase || $urandom_range(0, 4) != 0)
        send_item(CMD_CLEAR, $urandom_range(0, DEPTH-1), $urandom_range(0, DEPTH-1));
      first_phase = 1'b0;
      repeat (phase_len) insert_next(style);
      if ($urandom_range(0, 3) == 0) drain_results();
      style     = fill_style_t'($urandom_range(0, 2));
      phase_len = $urandom_range(8, 48);
      steady    = ($urandom_range(0, 3) == 0);
    end

    @(negedge clk);
    in_ch.valid = 1'b0;
    steady      = 1'b0;

    wait (awaited == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d items: %0d accepted inserts, %0d rejected inserts, %0d clears.",
             items_sent, n_inserted, n_rejected, n_cleared);
    $display("Peak running total %0d; one %0d-cycle receiver hold-off with input backed up.",
             peak_total, HOLD_OFF_CYCLES);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/oic_pkg.sv
rtl/core/oic_in_if.sv
rtl/core/oic_out_if.sv
rtl/core/oic_ram.sv
rtl/core/online_inversion_counter.sv
tb/oic_checker.sv
tb/tb.sv
